// ===== design/assert_macros.svh =====
// assertion macros for the design folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CHK_IMPL(label, clk, rst, ante, cons)
`define CHK_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/bee_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bee_pkg
// shared constants and types of the byte entropy estimator
// ----------------------------------------------------------------------------
package bee_pkg;
   localparam int LenBits  = 16;
   localparam int CntW     = LenBits + 1;
   localparam int LogFrac  = 24;
   localparam int MantBits = 30;
   localparam int KW       = 5;
   localparam int LogW     = KW + LogFrac;
   localparam int ProdW    = CntW + LogW;
   localparam int SumW     = ProdW + 8;
   localparam int QDepth   = 4;
   localparam int QAw      = 2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } word_type;
endpackage

// ===== design/bee_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bee_queue
// short fifo between the front and back parts
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module bee_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bee_pkg::word_type push_word,
   output logic              full,
   output logic              not_empty,
   input  logic              pop,
   output bee_pkg::word_type pop_word
);
   bee_pkg::word_type mem_ff [bee_pkg::QDepth];
   logic [bee_pkg::QAw-1:0] wp_ff, rp_ff;
   logic [bee_pkg::QAw:0]   cnt_ff;

   assign full      = (cnt_ff == bee_pkg::QAw'(0) + (bee_pkg::QAw+1)'(bee_pkg::QDepth));
   assign not_empty = (cnt_ff != '0);
   assign pop_word  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_word;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (bee_pkg::QAw+1)'(push) - (bee_pkg::QAw+1)'(pop);
      end
   end

   `CHK_IMPL(a_no_overrun, clock, reset, push, !full)
   `CHK_IMPL(a_no_underrun, clock, reset, pop, not_empty)
   `CHK_NEXT(a_cnt_hold, clock, reset, push && !pop, cnt_ff != '0)
endmodule

// ===== design/bee_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bee_back
// histogram update, final bin scan with shared log unit, result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module bee_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  bee_pkg::word_type q_word,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [15:0]       rsp_entropy_q12,
   output logic [16:0]       rsp_byte_count,
   output logic              rsp_overflow
);
   localparam int CW = bee_pkg::CntW;
   localparam int PW = bee_pkg::ProdW;
   localparam int SW = bee_pkg::SumW;
   localparam logic [CW-1:0] MaxCount = CW'(1) << bee_pkg::LenBits;

   typedef enum logic [8:0] {
      ST_CLEAR = 9'b000000001, ST_ACC = 9'b000000010, ST_RD = 9'b000000100,
      ST_LOG = 9'b000001000, ST_MUL = 9'b000010000, ST_ADD = 9'b000100000,
      ST_DIV = 9'b001000000, ST_OUT = 9'b010000000, ST_RMW = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] hist [256];
   logic [CW-1:0] rd_ff;
   logic [7:0] addr_ff;
   logic [8:0] scan_ff;      // 0..255 bins, 256 = total
   logic [CW-1:0] total_ff;
   logic ovf_ff;
   logic last_ff;
   logic [7:0] byte_ff;
   // log unit
   logic [CW-1:0] x_ff;
   logic [4:0] it_ff;
   logic [31:0] y_ff;
   logic [bee_pkg::LogFrac-1:0] frac_ff;
   logic [bee_pkg::KW-1:0] k_ff;
   logic [PW-1:0] prod_ff;
   logic [SW-1:0] sum_ff;
   // divider
   logic [SW-1:0] rem_ff;
   logic [15:0] quo_ff;
   logic [5:0] dit_ff;
   logic [SW-1:0] den;
   logic [63:0] sq;
   logic [bee_pkg::KW-1:0] kx;
   logic [SW:0] trial;

   always_comb begin
      kx = '0;
      for (int i = 0; i < CW; i++) if (x_ff[i]) kx = bee_pkg::KW'(i);
   end
   assign sq    = 64'(y_ff) * 64'(y_ff);
   assign den   = SW'(total_ff) << (bee_pkg::LogFrac - 12);
   assign q_pop = q_valid && (state_ff == ST_ACC);

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) hist[addr_ff] <= '0;
      else if (state_ff == ST_RMW && total_ff != MaxCount) hist[byte_ff] <= rd_ff + 1'b1;
      if (state_ff == ST_ACC && q_pop) rd_ff <= hist[q_word.data_byte];
      // forward the bin being written to the scan read of the same bin
      else if (state_ff == ST_RMW && byte_ff == addr_ff && total_ff != MaxCount)
         rd_ff <= rd_ff + 1'b1;
      else rd_ff <= hist[addr_ff];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (addr_ff == 8'hff) state_in = ST_ACC;
         ST_ACC:   if (q_pop) state_in = ST_RMW;
         ST_RMW:   state_in = last_ff ? ST_RD : ST_ACC;
         ST_RD:    state_in = ST_LOG;
         ST_LOG:   if (it_ff == 5'(bee_pkg::LogFrac)) state_in = ST_MUL;
         ST_MUL:   state_in = ST_ADD;
         ST_ADD:   state_in = scan_ff[8] ? ST_DIV : ST_RD;
         ST_DIV:   if (dit_ff == 6'd16) state_in = ST_OUT;
         ST_OUT:   if (rsp_ready) state_in = ST_CLEAR;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; addr_ff <= '0; total_ff <= '0; ovf_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_CLEAR: begin
               addr_ff <= addr_ff + 1'b1;
               total_ff <= '0; ovf_ff <= 1'b0;
            end
            ST_ACC: if (q_pop) begin
               byte_ff <= q_word.data_byte; last_ff <= q_word.last_byte;
               scan_ff <= '0; sum_ff <= '0; addr_ff <= '0;
            end
            ST_RMW: begin
               if (total_ff == MaxCount) ovf_ff <= 1'b1;
               else total_ff <= total_ff + 1'b1;
            end
            ST_RD: begin
               // rd_ff holds bin at addr_ff here; next bin is fetched during the log
               x_ff <= scan_ff[8] ? total_ff : rd_ff;
               it_ff <= '0; frac_ff <= '0;
               addr_ff <= addr_ff + 1'b1;
            end
            ST_LOG: begin
               if (it_ff == '0) begin
                  k_ff <= kx;
                  y_ff <= 32'(x_ff) << (bee_pkg::MantBits - int'(kx));
               end else begin
                  frac_ff <= {frac_ff[bee_pkg::LogFrac-2:0], sq[61]};
                  y_ff <= sq[61] ? 32'(sq[61:31]) : 32'(sq[60:30]);
               end
               it_ff <= it_ff + 1'b1;
            end
            ST_MUL: prod_ff <= PW'(x_ff) * PW'({k_ff, frac_ff});
            ST_ADD: begin
               if (scan_ff[8]) begin
                  rem_ff <= (SW'(prod_ff) > sum_ff ? SW'(prod_ff) - sum_ff : '0)
                            + (SW'(total_ff) << (bee_pkg::LogFrac - 13));
                  quo_ff <= '0; dit_ff <= '0;
               end else begin
                  sum_ff <= sum_ff + SW'(prod_ff);
                  scan_ff <= scan_ff + 1'b1;
               end
            end
            ST_DIV: if (dit_ff != 6'd16) begin
               // quotient fits 16 bits: s/n <= 8*2^24 plus half
               quo_ff <= {quo_ff[14:0], trial[SW] == 1'b0};
               if (!trial[SW]) rem_ff <= trial[SW-1:0] << 0;
               dit_ff <= dit_ff + 1'b1;
            end
            ST_OUT: if (rsp_ready) addr_ff <= '0;
            default: ;
         endcase
      end
   end

   // restoring division, bit 15 down to 0
   always_comb trial = {1'b0, rem_ff} - ({1'b0, den} << (5'd15 - dit_ff[4:0]));

   logic [15:0] ent;
   assign ent = (total_ff == '0) ? '0 : (quo_ff > 16'd32768 ? 16'd32768 : quo_ff);
   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_entropy_q12 = ent;
   assign rsp_byte_count  = 17'(total_ff);
   assign rsp_overflow    = ovf_ff;

   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `CHK_IMPL(a_pop_only_acc, clock, reset, q_pop, state_ff == ST_ACC)
   `CHK_IMPL(a_count_cap, clock, reset, 1'b1, total_ff <= MaxCount)
endmodule

// ===== design/bee_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bee_front
// accepts request words and pushes them into the queue
// ----------------------------------------------------------------------------
module bee_front (
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_data_byte,
   input  logic              req_last_byte,
   input  logic              q_full,
   output logic              q_push,
   output bee_pkg::word_type q_word
);
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;
   assign q_word    = '{data_byte: req_data_byte, last_byte: req_last_byte};
endmodule

// ===== design/byte_entropy_estimator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_entropy_estimator_core
// shannon entropy of a byte block, q12 bits per byte
// ----------------------------------------------------------------------------
// a non-last byte passes through the histogram read and read-modify-write states
// the last byte adds a scan of 257 logs (256 bins and the total), plus a restoring divide
// after each result a clearing pass wipes the histogram memory
// reset: synchronous; starts the clearing pass, bytes only queue up meanwhile
module byte_entropy_estimator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_entropy_q12,
   output logic [16:0] rsp_byte_count,
   output logic        rsp_overflow
);
   logic push, full, nempty, pop;
   bee_pkg::word_type in_word, out_word;

   // front: handshake into the queue
   bee_front u_front (.req_valid, .req_ready, .req_data_byte, .req_last_byte,
      .q_full(full), .q_push(push), .q_word(in_word));

   // queue: lets the front keep taking words while the back scans, until it is full
   bee_queue u_queue (.clock, .reset, .push, .push_word(in_word), .full,
      .not_empty(nempty), .pop, .pop_word(out_word));

   // back: histogram, log unit, divider and result register
   bee_back u_back (.clock, .reset, .q_valid(nempty), .q_word(out_word), .q_pop(pop),
      .rsp_valid, .rsp_ready, .rsp_entropy_q12, .rsp_byte_count, .rsp_overflow);
endmodule

// ===== verif/entropy_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// entropy_checker
// watches the byte and result channels, predicts each block's entropy, byte count
// and overflow flag, and compares every accepted result against the oldest prediction
// ----------------------------------------------------------------------------
module entropy_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [15:0] rsp_entropy_q12,
   input  logic [16:0] rsp_byte_count,
   input  logic        rsp_overflow,
   output int          errors,
   output int          pending
);
   typedef struct packed {
      logic [15:0] entropy_q12;
      logic [16:0] byte_count;
      logic        overflow;
   } block_result_type;

   logic [bee_pkg::CntW-1:0] hist [256];
   logic [bee_pkg::CntW-1:0] byte_total;
   logic                     sat_seen;
   block_result_type         expected_blocks [$];

   // log2 in q24: integer part from the top bit, fraction by repeated squaring
   function automatic longint unsigned log2_q24(input longint unsigned x);
      longint unsigned y;
      longint unsigned frac;
      int k;
      if (x == 0) return 0;
      k = 0;
      for (int i = 0; i < 64; i++) if (x[i]) k = i;
      if (k <= bee_pkg::MantBits) y = x << (bee_pkg::MantBits - k);
      else y = x >> (k - bee_pkg::MantBits);
      frac = 0;
      repeat (bee_pkg::LogFrac) begin
         y = (y * y) >> bee_pkg::MantBits;
         frac = frac << 1;
         if (y >= (64'd2 << bee_pkg::MantBits)) begin
            y = y >> 1;
            frac = frac | 1;
         end
      end
      return (longint'(k) << bee_pkg::LogFrac) | frac;
   endfunction

   function automatic logic [15:0] block_entropy_q12();
      longint unsigned n;
      longint unsigned sum;
      longint unsigned whole;
      longint unsigned s;
      longint unsigned q;
      n = byte_total;
      if (n == 0) return 0;
      sum = 0;
      for (int b = 0; b < 256; b++)
         if (hist[b] != 0) sum += longint'(hist[b]) * log2_q24(hist[b]);
      whole = n * log2_q24(n);
      s = (whole > sum) ? whole - sum : 0;
      q = (s + (n << (bee_pkg::LogFrac - 13))) / (n << (bee_pkg::LogFrac - 12));
      if (q > 32768) q = 32768;
      return q[15:0];
   endfunction

   always @(posedge clock) begin
      block_result_type got;
      block_result_type want;
      if (reset) begin
         errors = 0;
         for (int b = 0; b < 256; b++) hist[b] = '0;
         byte_total = '0;
         sat_seen = 1'b0;
         expected_blocks.delete();
      end else begin
         if (req_valid && req_ready) begin
            if (byte_total >= (bee_pkg::CntW'(1) << bee_pkg::LenBits)) sat_seen = 1'b1;
            else begin
               hist[req_data_byte] = hist[req_data_byte] + 1;
               byte_total = byte_total + 1;
            end
            if (req_last_byte) begin
               want.entropy_q12 = block_entropy_q12();
               want.byte_count = byte_total;
               want.overflow = sat_seen;
               expected_blocks.push_back(want);
               for (int b = 0; b < 256; b++) hist[b] = '0;
               byte_total = '0;
               sat_seen = 1'b0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_entropy_q12, rsp_byte_count, rsp_overflow};
            if (expected_blocks.size() == 0) begin
               $display("%0t: unexpected result word %h", $time, got);
               errors++;
            end else begin
               want = expected_blocks.pop_front();
               if (got.entropy_q12 !== want.entropy_q12) begin
                  $display("%0t: entropy_q12 expected %0d actual %0d", $time,
                     want.entropy_q12, got.entropy_q12);
                  errors++;
               end
               if (got.byte_count !== want.byte_count) begin
                  $display("%0t: byte_count expected %0d actual %0d", $time,
                     want.byte_count, got.byte_count);
                  errors++;
               end
               if (got.overflow !== want.overflow) begin
                  $display("%0t: overflow expected %0d actual %0d", $time,
                     want.overflow, got.overflow);
                  errors++;
               end
            end
         end
      end
      pending = expected_blocks.size();
   end
endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// byte entropy estimator test: directed blocks, one saturating block, then
// random blocks with random gaps on both channels
// ----------------------------------------------------------------------------
module tb;
   localparam int CycleLimit = 4000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_entropy_q12;
   logic [16:0] rsp_byte_count;
   logic        rsp_overflow;
   int          errors;
   int          pending;
   int          cycles = 0;
   bit          steady = 1'b0;   // no idling on either side while set

   always #1 clock = ~clock;

   byte_entropy_estimator_core dut (.*);

   entropy_checker checker_i (.*);

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result side back-pressure
   always @(posedge clock)
      rsp_ready <= steady || ($urandom_range(99) >= 35);

   // offer one word; valid stays up across back-to-back words
   task automatic send_word(input logic [7:0] b, input logic l);
      bit rdy;
      if (!steady && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 35);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= l;
      // ready only changes at rising edges, so sample it mid-cycle
      do begin
         @(negedge clock);
         rdy = req_ready;
         @(posedge clock);
      end while (!rdy);
   endtask

   task automatic send_block(input int len, input int alphabet);
      logic [7:0] base;
      base = $urandom_range(255);
      for (int i = 0; i < len; i++)
         send_word(alphabet >= 256 ? 8'($urandom_range(255))
                                   : base + 8'($urandom_range(alphabet - 1)),
                   i == len - 1);
   endtask

   initial begin
      int sent;
      int len;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: single byte block, single-valued block, extremes
      send_word(8'h00, 1'b1);
      send_word(8'hff, 1'b0);
      send_word(8'hff, 1'b0);
      send_word(8'hff, 1'b1);
      // two-symbol block with alternating bit patterns
      send_word(8'h55, 1'b0);
      send_word(8'haa, 1'b0);
      send_word(8'h55, 1'b0);
      send_word(8'haa, 1'b1);
      // uneven three-symbol block
      send_word(8'h01, 1'b0);
      send_word(8'h80, 1'b0);
      send_word(8'h80, 1'b0);
      send_word(8'h7f, 1'b1);
      // every value once: entropy at its 8.0 ceiling
      for (int v = 0; v < 256; v++) send_word(8'(v), v == 255);
      // saturating block: count tops out, extra words incl. the last one flag overflow
      steady = 1'b1;
      for (int i = 0; i < 65539; i++) send_word(8'($urandom_range(255)), i == 65538);
      steady = 1'b0;

      // random blocks, mostly short with small alphabets
      sent = 0;
      while (sent < 1000) begin
         steady = (sent >= 400 && sent < 550);
         len = ($urandom_range(9) == 0) ? $urandom_range(300, 1) : $urandom_range(30, 1);
         send_block(len, $urandom_range(3) == 0 ? 256 : $urandom_range(16, 1));
         sent += len;
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      // let the checker log the last accepted word before polling
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
